FILE: rtl/core/tristate_number_alu_top_defines.svh
// ----------------------------------------------------------------------------
// Tristate number ALU assertion macros
// Immediate and next-cycle implication checks, clocked on clk, off in reset.
// ----------------------------------------------------------------------------
`ifndef TRISTATE_NUMBER_ALU_TOP_DEFINES_SVH
`define TRISTATE_NUMBER_ALU_TOP_DEFINES_SVH

// same-cycle implication
`define TNA_ASSERT_IMPL(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define TNA_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

FILE: rtl/core/tna_pkg.sv
// ----------------------------------------------------------------------------
// Tristate number ALU package
// Opcodes, command kinds, queue entry and status types shared by the core.
// ----------------------------------------------------------------------------
package tna_pkg;

	localparam int DEFAULT_WORD_BITS   = 64;
	localparam int DEFAULT_QUEUE_DEPTH = 2;
	localparam int MAX_WORD_BITS       = 64;
	localparam int OP_BITS             = 4;
	localparam int SHAMT_BITS          = 6;

	localparam logic [OP_BITS-1:0] OP_ADD = 4'd0;
	localparam logic [OP_BITS-1:0] OP_SUB = 4'd1;
	localparam logic [OP_BITS-1:0] OP_AND = 4'd2;
	localparam logic [OP_BITS-1:0] OP_OR  = 4'd3;
	localparam logic [OP_BITS-1:0] OP_XOR = 4'd4;
	localparam logic [OP_BITS-1:0] OP_LSL = 4'd5;
	localparam logic [OP_BITS-1:0] OP_LSR = 4'd6;
	localparam logic [OP_BITS-1:0] OP_ASR = 4'd7;
	localparam logic [OP_BITS-1:0] OP_MUL = 4'd8;

	typedef enum logic [3:0] {
		KIND_ADD,
		KIND_SUB,
		KIND_AND,
		KIND_OR,
		KIND_XOR,
		KIND_LSL,
		KIND_LSR,
		KIND_ASR,
		KIND_MUL,
		KIND_BAD
	} kind_t;

	// queued request; word fields use the low WORD_BITS bits
	typedef struct packed {
		kind_t                   kind;
		logic [SHAMT_BITS-1:0]   shamt;
		logic [MAX_WORD_BITS-1:0] a_v;
		logic [MAX_WORD_BITS-1:0] a_m;
		logic [MAX_WORD_BITS-1:0] b_v;
		logic [MAX_WORD_BITS-1:0] b_m;
		logic [MAX_WORD_BITS-1:0] pre_v;  // a_v + b_v, or a_v - b_v for sub
		logic [MAX_WORD_BITS-1:0] pre_m;  // a_m + b_m
	} cmd_t;

	typedef struct packed {
		logic empty;
		logic full;
	} qstat_t;

	typedef struct packed {
		logic busy;
		logic fin;
	} bstat_t;

	typedef enum logic [2:0] {
		ST_IDLE = 3'b001,
		ST_MUL  = 3'b010,
		ST_FIN  = 3'b100
	} state_t;

endpackage

FILE: rtl/core/tna_front.sv
// ----------------------------------------------------------------------------
// Tristate number ALU front end
// Accepts requests, decodes the opcode and forms the first-level sums.
// ----------------------------------------------------------------------------
module tna_front #(
	parameter int WORD_BITS = tna_pkg::DEFAULT_WORD_BITS
) (
	input  logic                            in_valid,
	output logic                            in_ready,
	input  logic [tna_pkg::OP_BITS-1:0]     operation,
	input  logic [WORD_BITS-1:0]            a_value,
	input  logic [WORD_BITS-1:0]            a_mask,
	input  logic [WORD_BITS-1:0]            b_value,
	input  logic [WORD_BITS-1:0]            b_mask,
	input  logic [tna_pkg::SHAMT_BITS-1:0]  shift_amount,
	input  tna_pkg::qstat_t                 q_stat,
	output logic                            push,
	output tna_pkg::cmd_t                   push_cmd
);

	localparam int MW = tna_pkg::MAX_WORD_BITS;

	tna_pkg::kind_t       kind;
	logic [WORD_BITS-1:0] sum_v;
	logic [WORD_BITS-1:0] sum_m;
	logic [WORD_BITS-1:0] diff_v;

	always_comb begin
		unique case (operation)
			tna_pkg::OP_ADD: kind = tna_pkg::KIND_ADD;
			tna_pkg::OP_SUB: kind = tna_pkg::KIND_SUB;
			tna_pkg::OP_AND: kind = tna_pkg::KIND_AND;
			tna_pkg::OP_OR:  kind = tna_pkg::KIND_OR;
			tna_pkg::OP_XOR: kind = tna_pkg::KIND_XOR;
			tna_pkg::OP_LSL: kind = tna_pkg::KIND_LSL;
			tna_pkg::OP_LSR: kind = tna_pkg::KIND_LSR;
			tna_pkg::OP_ASR: kind = tna_pkg::KIND_ASR;
			tna_pkg::OP_MUL: kind = tna_pkg::KIND_MUL;
			default:         kind = tna_pkg::KIND_BAD;
		endcase
	end

	assign sum_v  = a_value + b_value;
	assign sum_m  = a_mask + b_mask;
	assign diff_v = a_value - b_value;

	assign in_ready = !q_stat.full;
	assign push     = in_valid && in_ready;

	always_comb begin
		push_cmd.kind  = kind;
		push_cmd.shamt = shift_amount;
		push_cmd.a_v   = MW'(a_value);
		push_cmd.a_m   = MW'(a_mask);
		push_cmd.b_v   = MW'(b_value);
		push_cmd.b_m   = MW'(b_mask);
		push_cmd.pre_v = (kind == tna_pkg::KIND_SUB) ? MW'(diff_v) : MW'(sum_v);
		push_cmd.pre_m = MW'(sum_m);
	end

endmodule

FILE: rtl/core/tna_queue.sv
// ----------------------------------------------------------------------------
// Tristate number ALU request queue
// Small circular queue between decode and execute.
// ----------------------------------------------------------------------------
module tna_queue #(
	parameter int DEPTH = tna_pkg::DEFAULT_QUEUE_DEPTH
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            push,
	input  tna_pkg::cmd_t   push_cmd,
	input  logic            pop,
	output logic            head_valid,
	output tna_pkg::cmd_t   head_cmd,
	output tna_pkg::qstat_t q_stat
);

	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);

	tna_pkg::cmd_t    entries_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] count_q;

	function automatic logic [PTR_W-1:0] next_ptr(input logic [PTR_W-1:0] p);
		return (p == PTR_W'(DEPTH - 1)) ? '0 : p + 1'b1;
	endfunction

	always_ff @(posedge clk) begin
		if (push) begin
			entries_q[wr_ptr_q] <= push_cmd;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= next_ptr(wr_ptr_q);
			end
			if (pop) begin
				rd_ptr_q <= next_ptr(rd_ptr_q);
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	assign head_valid   = (count_q != '0);
	assign head_cmd     = entries_q[rd_ptr_q];
	assign q_stat.empty = (count_q == '0);
	assign q_stat.full  = (count_q == CNT_W'(DEPTH));

endmodule

FILE: rtl/core/tna_back.sv
// ----------------------------------------------------------------------------
// Tristate number ALU back end
// Executes queued requests; multiply runs one bit of A per cycle.
// ----------------------------------------------------------------------------
module tna_back #(
	parameter int WORD_BITS = tna_pkg::DEFAULT_WORD_BITS
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 head_valid,
	input  tna_pkg::cmd_t        head_cmd,
	output logic                 pop,
	output tna_pkg::bstat_t      b_stat,
	output logic                 out_valid,
	input  logic                 out_ready,
	output logic [WORD_BITS-1:0] result_value,
	output logic [WORD_BITS-1:0] result_mask
);

	tna_pkg::state_t      state_q;
	logic                 out_valid_q;
	logic [WORD_BITS-1:0] res_v_q;
	logic [WORD_BITS-1:0] res_m_q;
	logic [WORD_BITS-1:0] av_q;
	logic [WORD_BITS-1:0] am_q;
	logic [WORD_BITS-1:0] bv_q;
	logic [WORD_BITS-1:0] bm_q;
	logic [WORD_BITS-1:0] known_q;
	logic [WORD_BITS-1:0] macc_q;

	logic [WORD_BITS-1:0] h_av;
	logic [WORD_BITS-1:0] h_am;
	logic [WORD_BITS-1:0] h_bv;
	logic [WORD_BITS-1:0] h_bm;
	logic [WORD_BITS-1:0] h_pv;
	logic [WORD_BITS-1:0] h_pm;
	logic [WORD_BITS-1:0] hi;
	logic [WORD_BITS-1:0] lo;
	logic [WORD_BITS-1:0] mu;
	logic [WORD_BITS-1:0] simple_v;
	logic [WORD_BITS-1:0] simple_m;
	logic                 head_mul;
	logic                 out_free;
	logic                 load_out;

	logic [WORD_BITS-1:0] step_add;
	logic [WORD_BITS-1:0] macc_sum;
	logic [WORD_BITS-1:0] fin_sum;
	logic [WORD_BITS-1:0] fin_mu;
	logic                 a_done;

	assign h_av = head_cmd.a_v[WORD_BITS-1:0];
	assign h_am = head_cmd.a_m[WORD_BITS-1:0];
	assign h_bv = head_cmd.b_v[WORD_BITS-1:0];
	assign h_bm = head_cmd.b_m[WORD_BITS-1:0];
	assign h_pv = head_cmd.pre_v[WORD_BITS-1:0];
	assign h_pm = head_cmd.pre_m[WORD_BITS-1:0];

	// second level of add and sub
	assign hi = h_pv + h_am;
	assign lo = h_pv - h_bm;

	always_comb begin
		mu       = '0;
		simple_v = '0;
		simple_m = '0;
		unique case (head_cmd.kind)
			tna_pkg::KIND_ADD: begin
				mu       = ((h_pm + h_pv) ^ h_pv) | h_am | h_bm;
				simple_v = h_pv & ~mu;
				simple_m = mu;
			end
			tna_pkg::KIND_SUB: begin
				mu       = (hi ^ lo) | h_am | h_bm;
				simple_v = h_pv & ~mu;
				simple_m = mu;
			end
			tna_pkg::KIND_AND: begin
				simple_v = h_av & h_bv;
				simple_m = (h_av | h_am) & (h_bv | h_bm) & ~(h_av & h_bv);
			end
			tna_pkg::KIND_OR: begin
				simple_v = h_av | h_bv;
				simple_m = (h_am | h_bm) & ~(h_av | h_bv);
			end
			tna_pkg::KIND_XOR: begin
				mu       = h_am | h_bm;
				simple_v = (h_av ^ h_bv) & ~mu;
				simple_m = mu;
			end
			tna_pkg::KIND_LSL: begin
				simple_v = h_av << head_cmd.shamt;
				simple_m = h_am << head_cmd.shamt;
			end
			tna_pkg::KIND_LSR: begin
				simple_v = h_av >> head_cmd.shamt;
				simple_m = h_am >> head_cmd.shamt;
			end
			tna_pkg::KIND_ASR: begin
				// shifts past the word fill with the sign, same as WORD_BITS-1
				simple_v = WORD_BITS'($signed(h_av) >>> head_cmd.shamt);
				simple_m = WORD_BITS'($signed(h_am) >>> head_cmd.shamt);
			end
			tna_pkg::KIND_MUL: begin
				simple_v = '0;
				simple_m = '0;
			end
			default: begin
				simple_v = '0;
				simple_m = '1;
			end
		endcase
	end

	// multiply step: value accumulator stays zero, so the tristate add
	// collapses to one add on the mask
	assign step_add = av_q[0] ? bm_q : (am_q[0] ? (bv_q | bm_q) : '0);
	assign macc_sum = macc_q + step_add;
	assign a_done   = ((av_q | am_q) == '0);

	assign fin_sum = macc_q + known_q;
	assign fin_mu  = (fin_sum ^ known_q) | macc_q;

	assign head_mul = (head_cmd.kind == tna_pkg::KIND_MUL);
	assign out_free = !out_valid_q || out_ready;
	assign pop      = (state_q == tna_pkg::ST_IDLE) && head_valid && (head_mul || out_free);
	// output register takes a new result: simple op popped, or multiply done
	assign load_out = (pop && !head_mul) || ((state_q == tna_pkg::ST_FIN) && out_free);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= tna_pkg::ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			if (load_out) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				tna_pkg::ST_IDLE: begin
					if (pop && head_mul) begin
						state_q <= tna_pkg::ST_MUL;
					end
				end
				tna_pkg::ST_MUL: begin
					if (a_done) begin
						state_q <= tna_pkg::ST_FIN;
					end
				end
				tna_pkg::ST_FIN: begin
					if (out_free) begin
						state_q <= tna_pkg::ST_IDLE;
					end
				end
				default: begin
					state_q <= tna_pkg::ST_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		unique case (state_q)
			tna_pkg::ST_IDLE: begin
				if (pop) begin
					// a multiply leaves a waiting result in place
					if (!head_mul) begin
						res_v_q <= simple_v;
						res_m_q <= simple_m;
					end
					av_q    <= h_av;
					am_q    <= h_am;
					bv_q    <= h_bv;
					bm_q    <= h_bm;
					known_q <= '0;
					macc_q  <= '0;
				end
			end
			tna_pkg::ST_MUL: begin
				if (!a_done) begin
					known_q <= known_q + (av_q[0] ? bv_q : '0);
					macc_q  <= macc_sum | macc_q | step_add;
					av_q    <= av_q >> 1;
					am_q    <= am_q >> 1;
					bv_q    <= bv_q << 1;
					bm_q    <= bm_q << 1;
				end
			end
			tna_pkg::ST_FIN: begin
				if (out_free) begin
					res_v_q <= known_q & ~fin_mu;
					res_m_q <= fin_mu;
				end
			end
			default: begin
			end
		endcase
	end

	assign b_stat.busy  = (state_q != tna_pkg::ST_IDLE);
	assign b_stat.fin   = (state_q == tna_pkg::ST_FIN);
	assign out_valid    = out_valid_q;
	assign result_value = res_v_q;
	assign result_mask  = res_m_q;

endmodule

FILE: rtl/core/tristate_number_alu_top.sv
// ----------------------------------------------------------------------------
// Tristate number ALU
// Abstract ALU over value/mask pairs: add, sub, bitwise, shifts, multiply.
// ----------------------------------------------------------------------------
//
//  channel  direction  handshake            payload
//  -------  ---------  -------------------  ---------------------------------
//  in       request    in_valid / in_ready  operation, a_value, a_mask,
//                                           b_value, b_mask, shift_amount
//  out      result     out_valid/out_ready  result_value, result_mask
//
//  Add, sub, bitwise and shift results show on out_valid after the accepting
//  edge writes the queue and a later pop, once the back end is idle and the
//  output register is free, executes into the output register. Multiply
//  shifts A until the highest set bit of a_value | a_mask is used up (at most
//  WORD_BITS); the back end's shift-and-add loop handles one bit of A per cycle.
//  Reset clears the queue pointers, the back-end state and the output valid.
//  A stalled result holds the back end; the queue keeps taking requests
//  until it fills, then in_ready drops.
//
`include "tristate_number_alu_top_defines.svh"

module tristate_number_alu_top #(
	parameter int WORD_BITS   = tna_pkg::DEFAULT_WORD_BITS,
	parameter int QUEUE_DEPTH = tna_pkg::DEFAULT_QUEUE_DEPTH
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            in_valid,
	output logic                            in_ready,
	input  logic [tna_pkg::OP_BITS-1:0]     operation,
	input  logic [WORD_BITS-1:0]            a_value,
	input  logic [WORD_BITS-1:0]            a_mask,
	input  logic [WORD_BITS-1:0]            b_value,
	input  logic [WORD_BITS-1:0]            b_mask,
	input  logic [tna_pkg::SHAMT_BITS-1:0]  shift_amount,
	output logic                            out_valid,
	input  logic                            out_ready,
	output logic [WORD_BITS-1:0]            result_value,
	output logic [WORD_BITS-1:0]            result_mask
);

	// front to queue
	logic            push;
	tna_pkg::cmd_t   push_cmd;
	tna_pkg::qstat_t q_stat;

	// queue to back
	logic            q_valid;
	logic            q_pop;
	tna_pkg::cmd_t   q_head;
	tna_pkg::bstat_t b_stat;

	// decode and first-level adds
	tna_front #(
		.WORD_BITS(WORD_BITS)
	) u_front (
		.in_valid    (in_valid),
		.in_ready    (in_ready),
		.operation   (operation),
		.a_value     (a_value),
		.a_mask      (a_mask),
		.b_value     (b_value),
		.b_mask      (b_mask),
		.shift_amount(shift_amount),
		.q_stat      (q_stat),
		.push        (push),
		.push_cmd    (push_cmd)
	);

	// decouples decode from execute
	tna_queue #(
		.DEPTH(QUEUE_DEPTH)
	) u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_cmd  (push_cmd),
		.pop       (q_pop),
		.head_valid(q_valid),
		.head_cmd  (q_head),
		.q_stat    (q_stat)
	);

	// execute, multiply loop and output register
	tna_back #(
		.WORD_BITS(WORD_BITS)
	) u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.head_valid  (q_valid),
		.head_cmd    (q_head),
		.pop         (q_pop),
		.b_stat      (b_stat),
		.out_valid   (out_valid),
		.out_ready   (out_ready),
		.result_value(result_value),
		.result_mask (result_mask)
	);

	// checks on the queue / back-end handoff
	`TNA_ASSERT_IMPL(a_pop_nonempty, q_pop, q_valid && !q_stat.empty, "pop from empty queue")
	`TNA_ASSERT_IMPL(a_pop_idle, b_stat.busy, !q_pop, "pop while back end busy")
	`TNA_ASSERT_NEXT(a_mul_busy, q_pop && (q_head.kind == tna_pkg::KIND_MUL), b_stat.busy, "multiply did not start")
	`TNA_ASSERT_IMPL(a_result_src, $rose(out_valid), $past(q_pop || b_stat.fin), "result without source")

endmodule

FILE: tb/testbench.sv
// ----------------------------------------------------------------------------
// Tristate number ALU testbench
// Drives directed and random requests through the valid/ready request channel,
// predicts each value/mask result in a local model and checks the results in
// order, with random idling on both sides and a forced back-pressure episode.
// ----------------------------------------------------------------------------
module testbench;

	localparam int WORD_BITS    = tna_pkg::DEFAULT_WORD_BITS;
	localparam int OP_BITS      = tna_pkg::OP_BITS;
	localparam int SHAMT_BITS   = tna_pkg::SHAMT_BITS;
	localparam int RANDOM_REQS  = 500;
	localparam int HOLD_AT      = 150;    // result count that starts the long hold-off
	localparam int HOLD_CYCLES  = 300;
	localparam int DRAIN_AT     = 250;    // random request that waits for a drained pipe
	localparam int TAIL_CYCLES  = 80;     // worst multiply latency plus margin
	localparam int FIRST_BAD_OP = 9;

	typedef logic [WORD_BITS-1:0] word_t;

	// one tristate number: mask bit 1 = unknown
	typedef struct {
		word_t v;
		word_t m;
	} tnum_t;

	typedef struct {
		logic [OP_BITS-1:0]    op;
		tnum_t                 a;
		tnum_t                 b;
		logic [SHAMT_BITS-1:0] shamt;
		bit                    drain;   // hold until every earlier result is back
	} alu_req_t;

	// ------------------------------------------------------------------------
	// DUT signals; every input known from time zero
	// ------------------------------------------------------------------------
	logic                  clk          = 1'b0;
	logic                  arst_n       = 1'b0;
	logic                  in_valid     = 1'b0;
	logic                  in_ready;
	logic [OP_BITS-1:0]    operation    = '0;
	word_t                 a_value      = '0;
	word_t                 a_mask       = '0;
	word_t                 b_value      = '0;
	word_t                 b_mask       = '0;
	logic [SHAMT_BITS-1:0] shift_amount = '0;
	logic                  out_valid;
	logic                  out_ready    = 1'b0;
	word_t                 result_value;
	word_t                 result_mask;

	alu_req_t pending_reqs[$];     // requests not yet offered
	tnum_t    expected_tnums[$];   // predicted results, oldest first
	alu_req_t cur_req;
	int       fail_count   = 0;
	int       results_seen = 0;
	int       hold_cnt     = 0;    // receiver long hold-off, owned by the checker
	int       send_gap     = 0;
	int       send_calm    = 0;
	int       send_calm_left = 0;
	int       recv_stall   = 0;
	int       recv_calm    = 0;
	int       recv_calm_left = 0;

	tristate_number_alu_top #(
		.WORD_BITS(WORD_BITS)
	) DUT (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.operation(operation),
		.a_value(a_value),
		.a_mask(a_mask),
		.b_value(b_value),
		.b_mask(b_mask),
		.shift_amount(shift_amount),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.result_value(result_value),
		.result_mask(result_mask)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// ------------------------------------------------------------------------
	// Tristate arithmetic model
	// ------------------------------------------------------------------------
	function automatic tnum_t mk_tnum(word_t v, word_t m);
		tnum_t t;
		t.v = v;
		t.m = m;
		return t;
	endfunction

	// carry-spread add: any bit a carry could differ in becomes unknown
	function automatic tnum_t spread_add(tnum_t x, tnum_t y);
		word_t sm, sv, carry, mu;
		sm    = x.m + y.m;
		sv    = x.v + y.v;
		carry = (sm + sv) ^ sv;
		mu    = carry | x.m | y.m;
		return mk_tnum(sv & ~mu, mu);
	endfunction

	// borrow-spread subtract: compare the highest and lowest possible differences
	function automatic tnum_t spread_sub(tnum_t x, tnum_t y);
		word_t dv, hi, lo, mu;
		dv = x.v - y.v;
		hi = dv + x.m;
		lo = dv - y.m;
		mu = (hi ^ lo) | x.m | y.m;
		return mk_tnum(dv & ~mu, mu);
	endfunction

	// known product plus an accumulated uncertainty from each bit of A
	function automatic tnum_t tnum_mul(tnum_t x, tnum_t y);
		word_t known;
		tnum_t acc;
		int    i;
		known = x.v * y.v;
		acc   = mk_tnum('0, '0);
		for (i = 0; i < WORD_BITS && (x.v | x.m) != '0; i++) begin
			if (x.v[0])
				acc = spread_add(acc, mk_tnum('0, y.m));
			else if (x.m[0])
				acc = spread_add(acc, mk_tnum('0, y.v | y.m));
			x.v = x.v >> 1;
			x.m = x.m >> 1;
			y.v = y.v << 1;
			y.m = y.m << 1;
		end
		return spread_add(mk_tnum(known, '0), acc);
	endfunction

	function automatic tnum_t predict_tnum(alu_req_t r);
		word_t v;
		case (r.op)
			tna_pkg::OP_ADD: return spread_add(r.a, r.b);
			tna_pkg::OP_SUB: return spread_sub(r.a, r.b);
			tna_pkg::OP_AND: begin
				v = r.a.v & r.b.v;
				return mk_tnum(v, (r.a.v | r.a.m) & (r.b.v | r.b.m) & ~v);
			end
			tna_pkg::OP_OR: begin
				v = r.a.v | r.b.v;
				return mk_tnum(v, (r.a.m | r.b.m) & ~v);
			end
			tna_pkg::OP_XOR: begin
				v = r.a.m | r.b.m;
				return mk_tnum((r.a.v ^ r.b.v) & ~v, v);
			end
			tna_pkg::OP_LSL: return mk_tnum(r.a.v << r.shamt, r.a.m << r.shamt);
			tna_pkg::OP_LSR: return mk_tnum(r.a.v >> r.shamt, r.a.m >> r.shamt);
			// sign of value and mask replicated independently
			tna_pkg::OP_ASR: return mk_tnum(word_t'($signed(r.a.v) >>> r.shamt),
				word_t'($signed(r.a.m) >>> r.shamt));
			tna_pkg::OP_MUL: return tnum_mul(r.a, r.b);
			default: return mk_tnum('0, '1);   // unused opcode: fully unknown
		endcase
	endfunction

	// ------------------------------------------------------------------------
	// Stimulus helpers
	// ------------------------------------------------------------------------
	function automatic word_t rand_word();
		return {$urandom, $urandom};
	endfunction

	function automatic word_t rand_mask();
		case ($urandom_range(0, 9))
			0, 1:    return '0;
			2, 3:    return rand_word() & rand_word() & rand_word();
			4, 5, 6: return rand_word();
			7, 8:    return rand_word() | rand_word();
			default: return '1;
		endcase
	endfunction

	// mostly well formed; a few with overlapping value and mask bits
	function automatic tnum_t rand_tnum();
		tnum_t t;
		t.m = rand_mask();
		case ($urandom_range(0, 19))
			0:       t.v = rand_word();
			1:       t.v = '1 & ~t.m;
			2:       t.v = {1'b1, {(WORD_BITS-1){1'b0}}} & ~t.m;
			default: t.v = rand_word() & ~t.m;
		endcase
		return t;
	endfunction

	// most idles short, a few long
	function automatic int draw_gap();
		int r;
		r = $urandom_range(0, 99);
		if (r < 50)
			return 0;
		else if (r < 88)
			return $urandom_range(1, 3);
		else if (r < 97)
			return $urandom_range(4, 12);
		else
			return $urandom_range(20, 60);
	endfunction

	task automatic queue_req(logic [OP_BITS-1:0] op, word_t av, word_t am, word_t bv,
		word_t bm, logic [SHAMT_BITS-1:0] sh, bit drain);
		alu_req_t r;
		r.op    = op;
		r.a     = mk_tnum(av, am);
		r.b     = mk_tnum(bv, bm);
		r.shamt = sh;
		r.drain = drain;
		pending_reqs.push_back(r);
	endtask

	task automatic queue_random_req(bit drain);
		alu_req_t r;
		word_t    keep;
		if ($urandom_range(0, 19) == 0)
			r.op = OP_BITS'($urandom_range(FIRST_BAD_OP, 15));
		else
			r.op = OP_BITS'($urandom_range(tna_pkg::OP_ADD, tna_pkg::OP_MUL));
		r.a = rand_tnum();
		r.b = rand_tnum();
		// keep most multiplies short: narrow A so the shift-add loop ends early
		if (r.op == tna_pkg::OP_MUL && $urandom_range(0, 9) < 6) begin
			keep  = '1 >> $urandom_range(1, WORD_BITS - 1);
			r.a.v = r.a.v & keep;
			r.a.m = r.a.m & keep;
		end
		case ($urandom_range(0, 7))
			0:       r.shamt = '0;
			1:       r.shamt = '1;
			default: r.shamt = SHAMT_BITS'($urandom_range(0, 63));
		endcase
		r.drain = drain;
		pending_reqs.push_back(r);
	endtask

	task automatic report_error(string msg);
		$display("ERROR t=%0t: %s", $realtime, msg);
		fail_count++;
	endtask

	// ------------------------------------------------------------------------
	// Request driver: offers queued requests, predicts on each accept.
	// Out of reset, in_valid gets exactly one NBA per edge; it never drops without an accept.
	// ------------------------------------------------------------------------
	always @(posedge clk) begin : drive_requests
		logic show;
		show = in_valid;
		if (arst_n) begin
			// quiet stretches with no sender idling
			if (send_calm_left == 0) begin
				send_calm_left = $urandom_range(20, 200);
				send_calm      = ($urandom_range(0, 3) == 0);
			end else begin
				send_calm_left--;
			end
			if (in_valid && in_ready) begin
				expected_tnums.push_back(predict_tnum(cur_req));
				show = 1'b0;
				// keep pushing while the receiver holds off so the queue fills
				send_gap = (send_calm || hold_cnt != 0) ? 0 : draw_gap();
			end
			if (!show) begin
				if (send_gap != 0) begin
					send_gap--;
				end else if (pending_reqs.size() != 0 &&
					!(pending_reqs[0].drain && expected_tnums.size() != 0)) begin
					cur_req      = pending_reqs.pop_front();
					show         = 1'b1;
					operation    <= cur_req.op;
					a_value      <= cur_req.a.v;
					a_mask       <= cur_req.a.m;
					b_value      <= cur_req.b.v;
					b_mask       <= cur_req.b.m;
					shift_amount <= cur_req.shamt;
				end
			end
			in_valid <= show;
		end
	end

	// ------------------------------------------------------------------------
	// Result checker and out_ready driver
	// ------------------------------------------------------------------------
	always @(posedge clk) begin : check_results
		logic  rdy;
		tnum_t want;
		int    n;
		if (arst_n) begin
			if (out_valid && out_ready) begin
				if (expected_tnums.size() == 0) begin
					report_error($sformatf("result %h/%h with nothing outstanding",
						result_value, result_mask));
				end else begin
					want = expected_tnums.pop_front();
					if (result_value !== want.v)
						report_error($sformatf("result %0d value %h, want %h",
							results_seen, result_value, want.v));
					if (result_mask !== want.m)
						report_error($sformatf("result %0d mask %h, want %h",
							results_seen, result_mask, want.m));
				end
				results_seen++;
				// one long back-pressure episode mid-run
				if (results_seen == HOLD_AT)
					hold_cnt = HOLD_CYCLES;
			end

			if (recv_calm_left == 0) begin
				recv_calm_left = $urandom_range(20, 200);
				recv_calm      = ($urandom_range(0, 3) == 0);
			end else begin
				recv_calm_left--;
			end

			if (hold_cnt != 0) begin
				hold_cnt--;
				rdy = 1'b0;
			end else if (recv_stall != 0) begin
				recv_stall--;
				rdy = 1'b0;
			end else begin
				n = (recv_calm || $urandom_range(0, 2) != 0) ? 0 : draw_gap();
				if (n != 0) begin
					recv_stall = n - 1;
					rdy        = 1'b0;
				end else begin
					rdy = 1'b1;
				end
			end
			out_ready <= rdy;
		end
	end

	// ------------------------------------------------------------------------
	// Sequence: directed corners, then random traffic, then drain and verdict
	// ------------------------------------------------------------------------
	initial begin : run_sequence
		word_t msb;
		int    i;
		msb = {1'b1, {(WORD_BITS-1){1'b0}}};

		// add: zero, known wrap, full unknown carry spread
		queue_req(tna_pkg::OP_ADD, '0, '0, '0, '0, '0, 1'b0);
		queue_req(tna_pkg::OP_ADD, '1, '0, word_t'(1), '0, '0, 1'b0);
		queue_req(tna_pkg::OP_ADD, word_t'(1), '0, '0, word_t'(1), '0, 1'b0);
		queue_req(tna_pkg::OP_ADD, '0, '1, '0, '1, '0, 1'b0);
		// sub: known borrow through every bit, unknown borrow
		queue_req(tna_pkg::OP_SUB, '0, '0, word_t'(1), '0, '0, 1'b0);
		queue_req(tna_pkg::OP_SUB, msb, '0, '0, word_t'(6), '0, 1'b0);
		// bitwise with mixed known/unknown bits
		queue_req(tna_pkg::OP_AND, 64'hF0F0_0000_FFFF_0000, 64'h0F0F_0000_0000_FFFF,
			64'hFF00_FF00_FF00_FF00, 64'h00FF_0000_00FF_0000, '0, 1'b0);
		queue_req(tna_pkg::OP_OR, 64'h0000_FFFF_0000_0000, 64'hFFFF_0000_0000_0000,
			'0, 64'h0000_0000_FFFF_FFFF, '0, 1'b0);
		queue_req(tna_pkg::OP_XOR, '1, '0, 64'h5555_5555_5555_5555,
			64'hAAAA_0000_0000_0000, '0, 1'b0);
		queue_req(tna_pkg::OP_XOR, '0, '1, '0, '1, '0, 1'b0);
		// shifts at zero and full distance
		queue_req(tna_pkg::OP_LSL, 64'h0123_4567_89AB_CDEF, 64'h1000_0000_0000_0001,
			'0, '0, '0, 1'b0);
		queue_req(tna_pkg::OP_LSL, word_t'(1), word_t'(2), '0, '0, '1, 1'b0);
		queue_req(tna_pkg::OP_LSR, msb, msb >> 1, '0, '0, '1, 1'b0);
		queue_req(tna_pkg::OP_LSR, '1, '0, '0, '0, SHAMT_BITS'(17), 1'b0);
		// arithmetic shift: value sign set, then mask sign set alone
		queue_req(tna_pkg::OP_ASR, msb | word_t'(5), '0, '0, '0, '1, 1'b0);
		queue_req(tna_pkg::OP_ASR, word_t'(64'h4000_0000_0000_0000), msb, '0, '0,
			SHAMT_BITS'(1), 1'b0);
		queue_req(tna_pkg::OP_ASR, msb, word_t'(1), '0, '0, '0, 1'b0);
		// multiply: empty A, full-width A (longest loop), unknown top bit, knowns
		queue_req(tna_pkg::OP_MUL, '0, '0, '1, '0, '0, 1'b0);
		queue_req(tna_pkg::OP_MUL, msb, '0, 64'h0000_0000_0000_0003,
			64'h0000_0000_0000_0004, '0, 1'b0);
		queue_req(tna_pkg::OP_MUL, word_t'(3), msb, word_t'(1), word_t'(2), '0, 1'b0);
		queue_req(tna_pkg::OP_MUL, '1, '0, '1, '0, '0, 1'b0);
		// unused opcodes
		queue_req(OP_BITS'(FIRST_BAD_OP), '1, '0, '1, '0, '1, 1'b0);
		queue_req(4'hF, '0, '1, '0, '1, '0, 1'b0);
		// overlapping value and mask bits
		queue_req(tna_pkg::OP_ADD, '1, '1, word_t'(7), word_t'(7), '0, 1'b0);
		queue_req(tna_pkg::OP_AND, '1, '1, '1, '0, '0, 1'b0);

		// first random request waits for the directed part to drain
		for (i = 0; i < RANDOM_REQS; i++)
			queue_random_req(i == 0 || i == DRAIN_AT);

		repeat (8) @(posedge clk);
		@(negedge clk) arst_n = 1'b1;

		while (pending_reqs.size() != 0 || in_valid)
			@(posedge clk);
		while (expected_tnums.size() != 0)
			@(posedge clk);
		repeat (TAIL_CYCLES) @(posedge clk);

		if (fail_count == 0) begin
			$display("[ OK ] regression clean");
		end else begin
			$display("[FAIL] regression broken");
		end
		$finish;
	end

	// hang guard: far beyond the slowest legal run
	initial begin : watchdog
		#5000000;
		$display("[FAIL] regression broken");
		$finish;
	end

endmodule
